FILE: hw/rtl/gbs_pkg.sv
// Package for the greedy box suppression block: sizes, field layout of the
// kept-box store and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package gbs_pkg;

  // Store size and stored coordinate width.
  localparam int MAX_KEPT   = 64;
  localparam int COORD_BITS = 16;

  // Fixed field widths of the channels.
  localparam int COORD_IN_W = 15;
  localparam int SIZE_W     = 14;
  localparam int THR_W      = 8;
  localparam int INDEX_W    = 13;
  localparam logic [THR_W-1:0]   THR_RESET = 8'd115;
  localparam logic [INDEX_W-1:0] INDEX_MAX = 13'h1FFF;

  // Derived widths.
  localparam int KIDX_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W   = $clog2(MAX_KEPT + 1);
  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int DIFF_W  = COORD_BITS + 2;
  localparam int WIDE_W  = 26;
  localparam int AREA_W  = 2 * SIZE_W;
  localparam int UNION_W = AREA_W + 1;
  localparam int INTER_W = 2 * DIFF_W;
  localparam int PROD_W  = UNION_W + THR_W;
  localparam int UCMP_W  = (INTER_W > UNION_W) ? INTER_W : UNION_W;
  localparam int CMP_W   = (INTER_W + 8 > PROD_W) ? INTER_W + 8 : PROD_W;

  // Kept-box entry layout: {left, top, right, bottom, area}.
  localparam int OFS_BOT   = AREA_W;
  localparam int OFS_RIGHT = OFS_BOT + EDGE_W;
  localparam int OFS_TOP   = OFS_RIGHT + EDGE_W;
  localparam int OFS_LEFT  = OFS_TOP + COORD_BITS;
  localparam int ENTRY_W   = OFS_LEFT + COORD_BITS;

  typedef struct packed {
    logic accept;  // load a new box
    logic issue;   // read the next kept box into the compare pipeline
    logic finish;  // store the box if kept and load the result register
  } gbs_cmd_t;

  typedef struct packed {
    logic scan_done;  // every kept box has been read
    logic pipe_busy;  // compares still in flight
  } gbs_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gbs_if.sv
// Channel interfaces of the greedy box suppression block: box input, result
// output and threshold write. Depends on gbs_pkg.
`default_nettype none

interface gbs_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   start_frame;
  logic signed [gbs_pkg::COORD_IN_W-1:0]  box_left;
  logic signed [gbs_pkg::COORD_IN_W-1:0]  box_top;
  logic        [gbs_pkg::SIZE_W-1:0]      box_width;
  logic        [gbs_pkg::SIZE_W-1:0]      box_height;

  modport source (output valid, start_frame, box_left, box_top, box_width, box_height,
                  input ready);
  modport sink (input valid, start_frame, box_left, box_top, box_width, box_height,
                output ready);
endinterface

interface gbs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          keep;
  logic [gbs_pkg::INDEX_W-1:0]   box_index;
  logic                          list_full;

  modport source (output valid, keep, box_index, list_full, input ready);
  modport sink (input valid, keep, box_index, list_full, output ready);
endinterface

interface gbs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [gbs_pkg::THR_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gbs_datapath.sv
// Datapath: box registers, kept-box RAM, the pipelined overlap compare,
// counters, threshold register and result payload. Depends on gbs_pkg, gbs_ram.
`default_nettype none

module gbs_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire gbs_pkg::gbs_cmd_t                     cmd,
  output gbs_pkg::gbs_sts_t                          sts,
  input  wire logic                                  in_start_frame,
  input  wire logic signed [gbs_pkg::COORD_IN_W-1:0] in_box_left,
  input  wire logic signed [gbs_pkg::COORD_IN_W-1:0] in_box_top,
  input  wire logic        [gbs_pkg::SIZE_W-1:0]     in_box_width,
  input  wire logic        [gbs_pkg::SIZE_W-1:0]     in_box_height,
  input  wire logic                                  cfg_valid,
  input  wire logic        [gbs_pkg::THR_W-1:0]      cfg_data,
  output logic                                       out_keep,
  output logic             [gbs_pkg::INDEX_W-1:0]    out_box_index,
  output logic                                       out_list_full
);

  // Current box.
  logic signed [gbs_pkg::COORD_BITS-1:0] box_l_r, box_t_r;
  logic signed [gbs_pkg::EDGE_W-1:0]     box_r_r, box_b_r;
  logic        [gbs_pkg::AREA_W-1:0]     area_r;
  logic signed [gbs_pkg::WIDE_W-1:0]     left_wide, top_wide, right_wide, bot_wide;

  logic [gbs_pkg::THR_W-1:0]   thr_r;
  logic [gbs_pkg::CNT_W-1:0]   count_r, ptr_r;
  logic [gbs_pkg::INDEX_W-1:0] frame_cnt_r;
  logic                        supp_r;

  logic [gbs_pkg::ENTRY_W-1:0] rd_data, wr_data;
  logic                        wr_en;

  // Pipeline valids: RAM data, edges, intersection, product.
  logic v1_r, v2_r, v3_r, v4_r;

  // Stage B signals.
  logic signed [gbs_pkg::COORD_BITS-1:0] k_l, k_t, ix0, iy0;
  logic signed [gbs_pkg::EDGE_W-1:0]     k_r, k_b, ix1, iy1;
  logic signed [gbs_pkg::DIFF_W-1:0]     dx, dy;
  logic [gbs_pkg::DIFF_W-1:0]            dx_r, dy_r;
  logic                                  ovl_r;
  logic [gbs_pkg::UNION_W-1:0]           sum_b_r, sum_c_r;

  // Stage C/D signals.
  logic [gbs_pkg::INTER_W-1:0]           inter_c_r, inter_d_r;
  logic [gbs_pkg::UCMP_W-1:0]            sum_wide, inter_wide, uni_wide;
  logic [gbs_pkg::UNION_W-1:0]           uni;
  logic [gbs_pkg::PROD_W-1:0]            prod_r;
  logic                                  over_thr;

  logic keep_now;

  assign left_wide  = gbs_pkg::WIDE_W'(in_box_left);
  assign top_wide   = gbs_pkg::WIDE_W'(in_box_top);
  assign right_wide = left_wide + gbs_pkg::WIDE_W'(in_box_width);
  assign bot_wide   = top_wide + gbs_pkg::WIDE_W'(in_box_height);

  assign sts = '{scan_done: (ptr_r == count_r), pipe_busy: (v1_r | v2_r | v3_r | v4_r)};

  assign keep_now = !supp_r;
  assign wr_en    = cmd.finish && keep_now && (count_r < gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT));
  assign wr_data  = {box_l_r, box_t_r, box_r_r, box_b_r, area_r};

  gbs_ram #(
    .WIDTH (gbs_pkg::ENTRY_W),
    .DEPTH (gbs_pkg::MAX_KEPT)
  ) u_kept_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[gbs_pkg::KIDX_W-1:0]),
    .wdata (wr_data),
    .re    (cmd.issue),
    .raddr (ptr_r[gbs_pkg::KIDX_W-1:0]),
    .rdata (rd_data)
  );

  // Stage B: intersection edges against one kept box.
  always_comb begin
    k_l = $signed(rd_data[gbs_pkg::OFS_LEFT  +: gbs_pkg::COORD_BITS]);
    k_t = $signed(rd_data[gbs_pkg::OFS_TOP   +: gbs_pkg::COORD_BITS]);
    k_r = $signed(rd_data[gbs_pkg::OFS_RIGHT +: gbs_pkg::EDGE_W]);
    k_b = $signed(rd_data[gbs_pkg::OFS_BOT   +: gbs_pkg::EDGE_W]);
    ix0 = (box_l_r > k_l) ? box_l_r : k_l;
    iy0 = (box_t_r > k_t) ? box_t_r : k_t;
    ix1 = (box_r_r < k_r) ? box_r_r : k_r;
    iy1 = (box_b_r < k_b) ? box_b_r : k_b;
    dx  = gbs_pkg::DIFF_W'(ix1) - gbs_pkg::DIFF_W'(ix0);
    dy  = gbs_pkg::DIFF_W'(iy1) - gbs_pkg::DIFF_W'(iy0);
  end

  // Stage D: union clamped at zero, then scaled by the threshold.
  always_comb begin
    sum_wide   = gbs_pkg::UCMP_W'(sum_c_r);
    inter_wide = gbs_pkg::UCMP_W'(inter_c_r);
    uni_wide   = (sum_wide >= inter_wide) ? sum_wide - inter_wide : '0;
    uni        = uni_wide[gbs_pkg::UNION_W-1:0];
  end

  assign over_thr = gbs_pkg::CMP_W'({inter_d_r, 8'h00}) > gbs_pkg::CMP_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= gbs_pkg::THR_RESET;
      count_r     <= '0;
      ptr_r       <= '0;
      frame_cnt_r <= '0;
      supp_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        thr_r <= cfg_data;
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (cmd.issue) begin
        ptr_r <= ptr_r + gbs_pkg::CNT_W'(1);
      end
      if (v4_r && over_thr) begin
        supp_r <= 1'b1;
      end
      if (cmd.accept) begin
        ptr_r  <= '0;
        supp_r <= 1'b0;
        if (in_start_frame) begin
          count_r     <= '0;
          frame_cnt_r <= '0;
        end
      end
      if (cmd.finish) begin
        if (wr_en) begin
          count_r <= count_r + gbs_pkg::CNT_W'(1);
        end
        if (frame_cnt_r != gbs_pkg::INDEX_MAX) begin
          frame_cnt_r <= frame_cnt_r + gbs_pkg::INDEX_W'(1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      box_l_r <= left_wide[gbs_pkg::COORD_BITS-1:0];
      box_t_r <= top_wide[gbs_pkg::COORD_BITS-1:0];
      box_r_r <= right_wide[gbs_pkg::EDGE_W-1:0];
      box_b_r <= bot_wide[gbs_pkg::EDGE_W-1:0];
      area_r  <= gbs_pkg::AREA_W'(in_box_width) * gbs_pkg::AREA_W'(in_box_height);
    end
    dx_r      <= dx;
    dy_r      <= dy;
    ovl_r     <= (dx > 0) && (dy > 0);
    sum_b_r   <= gbs_pkg::UNION_W'(area_r) +
                 gbs_pkg::UNION_W'(rd_data[gbs_pkg::AREA_W-1:0]);
    inter_c_r <= ovl_r ? gbs_pkg::INTER_W'(dx_r) * gbs_pkg::INTER_W'(dy_r) : '0;
    sum_c_r   <= sum_b_r;
    inter_d_r <= inter_c_r;
    prod_r    <= gbs_pkg::PROD_W'(thr_r) * gbs_pkg::PROD_W'(uni);
    if (cmd.finish) begin
      out_keep      <= keep_now;
      out_box_index <= frame_cnt_r;
      out_list_full <= keep_now && !wr_en;
    end
  end

  dp_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT))
    else $error("kept count above store size");

endmodule

`default_nettype wire

FILE: hw/rtl/gbs_ctrl.sv
// Controller state machine: input and output handshakes and the scan sequence
// over the kept-box store. Depends on gbs_pkg.
`default_nettype none

module gbs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire gbs_pkg::gbs_sts_t sts,
  output gbs_pkg::gbs_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.issue  = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  ctrl_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !sts.pipe_busy)
    else $error("result taken while compares in flight");

  ctrl_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !sts.scan_done)
    else $error("read issued past the kept count");

  ctrl_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished result not presented");

  ctrl_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_SCAN) && !out_valid_r || (state_r == ST_SCAN))
    else $error("accepted box did not start a scan");

endmodule

`default_nettype wire

FILE: hw/rtl/greedy_box_suppression_top.sv
// Top level of the greedy box suppression block: controller, datapath and the
// channel connections. Depends on gbs_pkg, gbs_if, gbs_ctrl, gbs_datapath.
//
//   channel  direction  payload                                         handshake
//   in_if    sink       start_frame, box_left/top/width/height          valid/ready
//   out_if   source     keep, box_index, list_full                      valid/ready
//   cfg_if   sink       overlap_threshold (8 bits)                      valid/ready
//
// Each box is compared against every stored box before the next input transaction: the
// kept-box RAM has one read port, so one stored box is compared per cycle, then a
// four-stage compare pipeline drains. Synchronous active-low reset clears the kept
// count, the frame index and sets the threshold to 115. A new box is taken while a
// result waits on a stalled output; the next result waits until that one is taken.
`default_nettype none

module greedy_box_suppression_top (
  input  wire logic clk,
  input  wire logic rst_n,
  gbs_in_if.sink    in_if,
  gbs_out_if.source out_if,
  gbs_cfg_if.sink   cfg_if
);

  gbs_pkg::gbs_cmd_t cmd;
  gbs_pkg::gbs_sts_t sts;

  assign cfg_if.ready = 1'b1;

  gbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbs_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_start_frame (in_if.start_frame),
    .in_box_left    (in_if.box_left),
    .in_box_top     (in_if.box_top),
    .in_box_width   (in_if.box_width),
    .in_box_height  (in_if.box_height),
    .cfg_valid      (cfg_if.valid),
    .cfg_data       (cfg_if.data),
    .out_keep       (out_if.keep),
    .out_box_index  (out_if.box_index),
    .out_list_full  (out_if.list_full)
  );

endmodule

`default_nettype wire

FILE: tb/gbs_nms_checker.sv
// Checker for the greedy box suppression block: follows the box, result and threshold
// channels, predicts every result and compares it with what the block returns.
// Depends on gbs_pkg.
module gbs_nms_checker
  import gbs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_start_frame,
  input  logic signed [COORD_IN_W-1:0] in_box_left,
  input  logic signed [COORD_IN_W-1:0] in_box_top,
  input  logic        [SIZE_W-1:0]     in_box_width,
  input  logic        [SIZE_W-1:0]     in_box_height,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         out_keep,
  input  logic        [INDEX_W-1:0]    out_box_index,
  input  logic                         out_list_full,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic        [THR_W-1:0]      cfg_data,
  output int                           fail_count,
  output int                           results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               keep;
    logic [INDEX_W-1:0] box_index;
    logic               list_full;
  } nms_result_t;

  nms_result_t      expected_q[$];
  logic [THR_W-1:0] threshold;
  longint           held_left[MAX_KEPT];
  longint           held_top[MAX_KEPT];
  longint           held_right[MAX_KEPT];
  longint           held_bottom[MAX_KEPT];
  longint           held_area[MAX_KEPT];
  int               held_count;
  int               frame_pos;
  int               mismatches = 0;
  int               results_seen = 0;

  assign fail_count = mismatches;

  // Two's complement value of the low bits of v, as a store register of that width holds it.
  function automatic longint wrap_to(longint v, int bits);
    longint span;
    span = longint'(1) << bits;
    v = v & (span - 1);
    if (v >= (span >>> 1)) v = v - span;
    return v;
  endfunction

  function automatic nms_result_t suppress_box(logic sf, logic signed [COORD_IN_W-1:0] bl,
                                               logic signed [COORD_IN_W-1:0] bt,
                                               logic [SIZE_W-1:0] bw, logic [SIZE_W-1:0] bh);
    longint      l, t, r, b, area;
    longint      ix0, iy0, ix1, iy1, inter, uni;
    logic        keep;
    nms_result_t res;
    keep = 1'b1;
    res.list_full = 1'b0;
    if (sf) begin
      held_count = 0;
      frame_pos = 0;
    end
    l = wrap_to(longint'(bl), COORD_BITS);
    t = wrap_to(longint'(bt), COORD_BITS);
    r = wrap_to(longint'(bl) + longint'(bw), EDGE_W);
    b = wrap_to(longint'(bt) + longint'(bh), EDGE_W);
    area = (longint'(bw) * longint'(bh)) & ((longint'(1) << AREA_W) - 1);
    for (int j = 0; j < held_count; j++) begin
      ix0 = (l > held_left[j]) ? l : held_left[j];
      iy0 = (t > held_top[j]) ? t : held_top[j];
      ix1 = (r < held_right[j]) ? r : held_right[j];
      iy1 = (b < held_bottom[j]) ? b : held_bottom[j];
      inter = (ix1 > ix0 && iy1 > iy0) ? (ix1 - ix0) * (iy1 - iy0) : 0;
      uni = area + held_area[j];
      uni = (uni >= inter) ? uni - inter : 0;
      if (inter * 256 > longint'(threshold) * uni) keep = 1'b0;
    end
    if (keep) begin
      if (held_count < MAX_KEPT) begin
        held_left[held_count] = l;
        held_top[held_count] = t;
        held_right[held_count] = r;
        held_bottom[held_count] = b;
        held_area[held_count] = area;
        held_count++;
      end else begin
        res.list_full = 1'b1;
      end
    end
    res.keep = keep;
    res.box_index = INDEX_W'(frame_pos);
    if (frame_pos < int'(INDEX_MAX)) frame_pos++;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 30) $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_result();
    nms_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result arrived with no box transaction outstanding");
    end else begin
      want = expected_q.pop_front();
      if (out_keep !== want.keep)
        report_mismatch($sformatf("keep got %0b expected %0b", out_keep, want.keep));
      if (out_box_index !== want.box_index)
        report_mismatch($sformatf("box_index got %0d expected %0d", out_box_index,
                                  want.box_index));
      if (out_list_full !== want.list_full)
        report_mismatch($sformatf("list_full got %0b expected %0b", out_list_full,
                                  want.list_full));
    end
    results_seen++;
  endtask

  // Result before box in the same cycle: a result never belongs to a box taken at that edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      threshold = THR_RESET;
      held_count = 0;
      frame_pos = 0;
      expected_q.delete();
      results_pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready)
        expected_q.insert(expected_q.size(),
                          suppress_box(in_start_frame, in_box_left, in_box_top,
                                       in_box_width, in_box_height));
      results_pending <= expected_q.size();
    end
  end

endmodule

FILE: tb/tb_greedy_box_suppression_top.sv
// Testbench top for greedy_box_suppression_top: clock, reset, box and threshold stimulus,
// result-side stalls and the final verdict. Depends on gbs_pkg, gbs_if and gbs_nms_checker.
module tb_greedy_box_suppression_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gbs_pkg::*;

  localparam longint CYCLE_LIMIT = 25_000_000;
  localparam int     LONG_HOLD   = 400;
  localparam int     GRID_CELL   = 1024;

  typedef struct {
    logic                         start;
    logic signed [COORD_IN_W-1:0] left;
    logic signed [COORD_IN_W-1:0] top;
    logic        [SIZE_W-1:0]     width;
    logic        [SIZE_W-1:0]     height;
  } box_t;

  logic   clk;
  logic   rst_n;
  int     fail_count;
  int     results_pending;
  longint cycles;
  bit     quiet = 1'b0;
  int     hold_requests = 0;
  int     holds_served = 0;
  box_t   recent[8];
  int     n_recent = 0;

  gbs_in_if  in_ch ();
  gbs_out_if out_ch ();
  gbs_cfg_if cfg_ch ();

  greedy_box_suppression_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  gbs_nms_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_start_frame  (in_ch.start_frame),
    .in_box_left     (in_ch.box_left),
    .in_box_top      (in_ch.box_top),
    .in_box_width    (in_ch.box_width),
    .in_box_height   (in_ch.box_height),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_keep        (out_ch.keep),
    .out_box_index   (out_ch.box_index),
    .out_list_full   (out_ch.list_full),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_data        (cfg_ch.data),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic int jit(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic box_t mk_box(bit s, int l, int t, int w, int h);
    box_t b;
    if (l < -16384) l = -16384;
    if (l > 16383) l = 16383;
    if (t < -16384) t = -16384;
    if (t > 16383) t = 16383;
    if (w < 0) w = 0;
    if (w > 16383) w = 16383;
    if (h < 0) h = 0;
    if (h > 16383) h = 16383;
    b.start = s;
    b.left = l[COORD_IN_W-1:0];
    b.top = t[COORD_IN_W-1:0];
    b.width = w[SIZE_W-1:0];
    b.height = h[SIZE_W-1:0];
    return b;
  endfunction

  // Offers one box, holds it until the block takes it, then idles for a random gap.
  task automatic send_box(box_t b);
    int g;
    in_ch.valid <= 1'b1;
    in_ch.start_frame <= b.start;
    in_ch.box_left <= b.left;
    in_ch.box_top <= b.top;
    in_ch.box_width <= b.width;
    in_ch.box_height <= b.height;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    recent[n_recent % 8] = b;
    n_recent++;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // The count from the checker is registered, so look at it only after the next edge.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic box_t pick_recent();
    return recent[$urandom_range(0, (n_recent < 8 ? n_recent : 8) - 1)];
  endfunction

  // Boxes around a few centers so that suppression happens often, mixed with noise.
  task automatic random_frame(int n);
    box_t b, p;
    int   kind, pl, pt, pw, ph;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 99);
      if (n_recent > 0) p = pick_recent();
      pl = int'(p.left);
      pt = int'(p.top);
      pw = int'(p.width);
      ph = int'(p.height);
      if (k == 0 || n_recent == 0 || kind < 15) begin
        b = mk_box(1'b0, jit(2000), jit(2000), $urandom_range(16, 1200),
                   $urandom_range(16, 1200));
      end else if (kind < 65) begin
        b = mk_box(1'b0, pl + jit(pw / 3 + 4), pt + jit(ph / 3 + 4), pw + jit(pw / 4 + 2),
                   ph + jit(ph / 4 + 2));
      end else if (kind < 75) begin
        b.left = COORD_IN_W'($urandom);
        b.top = COORD_IN_W'($urandom);
        b.width = SIZE_W'($urandom);
        b.height = SIZE_W'($urandom);
      end else if (kind < 82) begin
        if ($urandom_range(0, 1) == 0) b = mk_box(1'b0, pl + jit(8), pt + jit(8), 0, ph);
        else b = mk_box(1'b0, pl + jit(8), pt + jit(8), pw, 0);
      end else if (kind < 89) begin
        if ($urandom_range(0, 1) == 0) b = mk_box(1'b0, pl + pw, pt, $urandom_range(1, 800), ph);
        else b = mk_box(1'b0, pl, pt + ph, pw, $urandom_range(1, 800));
      end else if (kind < 95) begin
        b = p;
      end else begin
        b = mk_box(1'b0, pl - $urandom_range(0, 3000), pt - $urandom_range(0, 3000),
                   $urandom_range(3000, 16383), $urandom_range(3000, 16383));
      end
      b.start = (k == 0) || ($urandom_range(0, 49) == 0);
      send_box(b);
    end
  endtask

  // Disjoint boxes on a grid overflow the kept store; a few overlapping boxes follow.
  task automatic grid_frame(int n);
    box_t b, first_box;
    for (int k = 0; k < n; k++) begin
      b = mk_box(k == 0, -16000 + (k % 12) * GRID_CELL, -16000 + (k / 12) * GRID_CELL,
                 $urandom_range(GRID_CELL / 2, GRID_CELL), $urandom_range(GRID_CELL / 2, GRID_CELL));
      if (k == 0) first_box = b;
      send_box(b);
    end
    b = first_box;
    b.start = 1'b0;
    send_box(b);
    for (int k = 0; k < 3; k++) begin
      b = pick_recent();
      b.start = 1'b0;
      b.left = b.left + COORD_IN_W'($urandom_range(0, 3));
      send_box(b);
    end
  endtask

  function automatic logic [THR_W-1:0] phase_threshold(int ph);
    case (ph)
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      4: return 8'd128;
      5: return THR_RESET;
      default: return THR_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Result side: random stalls, plus a long hold whenever the stimulus asks for one.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_requests != holds_served) begin
        holds_served++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = gap_len();
        @(posedge clk);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("greedy_box_suppression_top verification failed");
    $finish;
  end

  initial begin
    int   sent, n;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.start_frame <= 1'b0;
    in_ch.box_left <= '0;
    in_ch.box_top <= '0;
    in_ch.box_width <= '0;
    in_ch.box_height <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed boxes at the reset threshold: duplicates, shared edges, empty boxes, extremes.
    send_box(mk_box(1'b1, 0, 0, 160, 160));
    send_box(mk_box(1'b0, 0, 0, 160, 160));
    send_box(mk_box(1'b0, 160, 0, 160, 160));
    send_box(mk_box(1'b0, 0, 160, 160, 160));
    send_box(mk_box(1'b0, 40, 40, 0, 160));
    send_box(mk_box(1'b0, 40, 40, 0, 160));
    send_box(mk_box(1'b0, 40, 40, 160, 0));
    send_box(mk_box(1'b0, 40, 0, 160, 160));
    send_box(mk_box(1'b0, 80, 0, 160, 160));
    send_box(mk_box(1'b0, -16384, -16384, 16383, 16383));
    send_box(mk_box(1'b0, 16383, 16383, 16383, 16383));
    send_box(mk_box(1'b0, -16384, 16383, 16383, 0));
    send_box(mk_box(1'b0, 16383, -16384, 0, 16383));
    send_box(mk_box(1'b0, -1, -1, 1, 1));

    // With a zero threshold any overlap at all suppresses.
    write_threshold(8'd0);
    send_box(mk_box(1'b1, 0, 0, 160, 160));
    send_box(mk_box(1'b0, 159, 159, 16, 16));
    send_box(mk_box(1'b0, 160, 160, 16, 16));
    send_box(mk_box(1'b0, 500, 500, 0, 0));
    send_box(mk_box(1'b0, 500, 500, 0, 0));

    write_threshold(8'd255);
    send_box(mk_box(1'b1, 0, 0, 160, 160));
    send_box(mk_box(1'b0, 0, 0, 160, 160));
    send_box(mk_box(1'b0, 1, 0, 160, 160));
    grid_frame(68);

    for (int ph = 0; ph < 9; ph++) begin
      write_threshold(phase_threshold(ph));
      quiet = (ph == 3);
      sent = 0;
      while (sent < 190) begin
        if ($urandom_range(0, 9) == 0) begin
          n = $urandom_range(66, 75);
          grid_frame(n);
          sent += n + 4;
        end else begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(3, 30);
          random_frame(n);
          sent += n;
        end
        if ($urandom_range(0, 19) == 0) wait_idle();
      end
      if (ph == 5) begin
        // Results are held back while boxes keep coming, so the input side backs up.
        hold_requests++;
        quiet = 1'b1;
        random_frame(40);
        quiet = 1'b0;
        wait_idle();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("greedy_box_suppression_top verification clean");
    end else begin
      $display("greedy_box_suppression_top verification failed");
    end
    $finish;
  end

endmodule
